/* rtl/i2c_register_bank_with_timeout_core_macros.svh */
// Assertion macros for the I2C register bank.
// Used by the top level; expects clk and arst_n in scope.
`ifndef I2C_REGISTER_BANK_WITH_TIMEOUT_CORE_MACROS_SVH
`define I2C_REGISTER_BANK_WITH_TIMEOUT_CORE_MACROS_SVH

// checked on every edge outside reset
`define I2CRB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define I2CRB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/i2crb_pkg.sv */
// Shared types and constants for the I2C register bank.
// No dependencies; used by the channel interfaces and the top level.
package i2crb_pkg;

	localparam int CMD_W       = 3;
	localparam int BYTE_W      = 8;
	localparam int LIDX_W      = 4;
	localparam int MASK_BITS   = 16;
	localparam int PTR_OUT_W   = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int DATA_VALUES = 256;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE      = 3'd0,
		CMD_READ       = 3'd1,
		CMD_STOP       = 3'd2,
		CMD_TICK       = 3'd3,
		CMD_LOCAL_READ = 3'd4
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WRITABLE_MASK = 2'd0,
		CFG_TIMEOUT_MASK  = 2'd1,
		CFG_TIMEOUT_MS    = 2'd2
	} cfg_idx_t;

	localparam logic [MASK_BITS-1:0]  WRITABLE_RST   = 16'hFFF8;
	localparam logic [MASK_BITS-1:0]  TIMEOUT_RST    = 16'h01F8;
	localparam logic [CFG_DATA_W-1:0] TIMEOUT_MS_RST = 16'd500;

endpackage

/* rtl/i2crb_in_if.sv */
// Input event channel of the I2C register bank.
// Depends on i2crb_pkg for field widths.
interface i2crb_in_if;
	logic                            valid;
	logic                            ready;
	logic [i2crb_pkg::CMD_W-1:0]     command;
	logic [i2crb_pkg::BYTE_W-1:0]    data_byte;
	logic [i2crb_pkg::LIDX_W-1:0]    local_index;

	modport source (output valid, command, data_byte, local_index, input ready);
	modport sink (input valid, command, data_byte, local_index, output ready);
endinterface

/* rtl/i2crb_out_if.sv */
// Result channel of the I2C register bank.
// Depends on i2crb_pkg for field widths.
interface i2crb_out_if;
	logic                              valid;
	logic                              ready;
	logic [i2crb_pkg::BYTE_W-1:0]      read_data;
	logic [i2crb_pkg::MASK_BITS-1:0]   modified_mask;
	logic [i2crb_pkg::PTR_OUT_W-1:0]   pointer;

	modport source (output valid, read_data, modified_mask, pointer, input ready);
	modport sink (input valid, read_data, modified_mask, pointer, output ready);
endinterface

/* rtl/i2crb_cfg_if.sv */
// Configuration write channel of the I2C register bank.
// Depends on i2crb_pkg for field widths.
interface i2crb_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [i2crb_pkg::CFG_IDX_W-1:0]    index;
	logic [i2crb_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/i2c_register_bank_with_timeout_core.sv */
// I2C target register bank with auto-increment pointer and per-register timeouts.
// Each item passes from the input register to the result register, which drives result valid.
// Throughput: one item per cycle unless the result channel stalls; state and timers update as an item advances.
// arst_n clears control state, loads register i with i+1 and the masks and timeout period with defaults.
// Depends on i2crb_pkg, the three channel interfaces and the macros header.
`include "i2c_register_bank_with_timeout_core_macros.svh"

module i2c_register_bank_with_timeout_core
	import i2crb_pkg::*;
#(
	parameter int REGISTERS  = 16,
	parameter int TIMER_BITS = 16
) (
	input logic          clk,
	input logic          arst_n,
	i2crb_in_if.sink     item_in,
	i2crb_out_if.source  result_out,
	i2crb_cfg_if.sink    cfg
);

	localparam int PW = $clog2(REGISTERS);
	localparam int NT = (REGISTERS < MASK_BITS) ? REGISTERS : MASK_BITS;
	localparam int CW = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;
	localparam logic [TIMER_BITS-1:0] TMR_CAP = {TIMER_BITS{1'b1}};

	// configuration
	logic [MASK_BITS-1:0]  writable_mask_q;
	logic [MASK_BITS-1:0]  timeout_mask_q;
	logic [CFG_DATA_W-1:0] timeout_ms_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			writable_mask_q <= WRITABLE_RST;
			timeout_mask_q  <= TIMEOUT_RST;
			timeout_ms_q    <= TIMEOUT_MS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_WRITABLE_MASK: writable_mask_q <= cfg.data;
				CFG_TIMEOUT_MASK:  timeout_mask_q  <= cfg.data;
				CFG_TIMEOUT_MS:    timeout_ms_q    <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// input stage
	logic              s1_valid_q;
	logic [CMD_W-1:0]  cmd_s1;
	logic [BYTE_W-1:0] data_s1;
	logic [LIDX_W-1:0] lidx_s1;
	logic              res_valid_q;
	logic              advance;

	assign advance       = s1_valid_q && (!res_valid_q || result_out.ready);
	assign item_in.ready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (item_in.ready) begin
			s1_valid_q <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.ready) begin
			cmd_s1  <= item_in.command;
			data_s1 <= item_in.data_byte;
			lidx_s1 <= item_in.local_index;
		end
	end

	// bank state
	logic [PW-1:0]         ptr_q;
	logic                  addr_rcvd_q;
	logic [BYTE_W-1:0]     val_q [REGISTERS];
	logic [NT-1:0]         run_q;
	logic [NT-1:0]         mod_q;
	logic [TIMER_BITS-1:0] elapsed_q [NT];

	// loaded address is the data byte modulo the register count
	logic [PW-1:0] mod_tab [DATA_VALUES];
	for (genvar d = 0; d < DATA_VALUES; d++) begin : g_mod
		assign mod_tab[d] = PW'(d % REGISTERS);
	end

	logic          do_write, do_tick, do_lread;
	logic          wr_hit, lidx_ok;
	logic [PW-1:0] lidx_idx;
	logic [PW-1:0] ptr_inc;
	logic [PW-1:0] ptr_n;
	logic          addr_rcvd_n;
	logic [BYTE_W-1:0] rd_n;
	logic [REGISTERS-1:0] wr_sel;
	logic [REGISTERS-1:0] fire;
	logic [NT-1:0]        mod_n;

	assign do_write = advance && (cmd_s1 == CMD_WRITE);
	assign do_tick  = advance && (cmd_s1 == CMD_TICK);
	assign lidx_ok  = int'(lidx_s1) < REGISTERS;
	assign do_lread = advance && (cmd_s1 == CMD_LOCAL_READ) && lidx_ok;
	assign lidx_idx = PW'(lidx_s1);

	// registers past the mask width are read-only
	assign wr_hit  = do_write && addr_rcvd_q && (int'(ptr_q) < MASK_BITS)
		&& writable_mask_q[PTR_OUT_W'(ptr_q)];
	assign ptr_inc = (ptr_q == PW'(REGISTERS - 1)) ? '0 : ptr_q + PW'(1);

	always_comb begin
		ptr_n       = ptr_q;
		addr_rcvd_n = addr_rcvd_q;
		rd_n        = '0;
		case (cmd_s1)
			CMD_WRITE: begin
				if (!addr_rcvd_q) begin
					ptr_n       = mod_tab[data_s1];
					addr_rcvd_n = 1'b1;
				end else begin
					ptr_n = ptr_inc;
				end
			end
			CMD_READ: begin
				rd_n  = val_q[ptr_q];
				ptr_n = ptr_inc;
			end
			CMD_STOP: begin
				addr_rcvd_n = 1'b0;
			end
			CMD_LOCAL_READ: begin
				if (lidx_ok) begin
					rd_n = val_q[lidx_idx];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			addr_rcvd_q <= 1'b0;
		end else if (advance) begin
			ptr_q       <= ptr_n;
			addr_rcvd_q <= addr_rcvd_n;
		end
	end

	// per-register timeout counter and modified flag
	for (genvar i = 0; i < REGISTERS; i++) begin : g_reg
		if (i < NT) begin : g_live
			logic [TIMER_BITS-1:0] el_inc;
			logic                  counting;

			assign wr_sel[i] = wr_hit && (ptr_q == PW'(i));
			assign counting  = do_tick && timeout_mask_q[i] && run_q[i];
			assign el_inc    = (elapsed_q[i] == TMR_CAP) ? elapsed_q[i]
				: elapsed_q[i] + TIMER_BITS'(1);
			assign fire[i]   = counting && (CW'(el_inc) > CW'(timeout_ms_q));
			assign mod_n[i]  = (mod_q[i] && !(do_lread && (lidx_idx == PW'(i))))
				|| wr_sel[i] || fire[i];

			always_ff @(posedge clk) begin
				if (wr_sel[i] && timeout_mask_q[i]) begin
					elapsed_q[i] <= '0;
				end else if (counting) begin
					elapsed_q[i] <= el_inc;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					run_q[i] <= 1'b0;
					mod_q[i] <= 1'b0;
				end else begin
					mod_q[i] <= mod_n[i];
					if (wr_sel[i] && timeout_mask_q[i]) begin
						run_q[i] <= 1'b1;
					end else if (fire[i]) begin
						run_q[i] <= 1'b0;
					end
				end
			end
		end else begin : g_fixed
			assign wr_sel[i] = 1'b0;
			assign fire[i]   = 1'b0;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				val_q[i] <= BYTE_W'(i + 1);
			end else if (wr_sel[i]) begin
				val_q[i] <= data_s1;
			end else if (fire[i]) begin
				val_q[i] <= '0;
			end
		end
	end

	// result register
	logic [BYTE_W-1:0]    rd_q;
	logic [MASK_BITS-1:0] mmask_q;
	logic [PTR_OUT_W-1:0] ptr_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rd_q      <= rd_n;
			mmask_q   <= MASK_BITS'(mod_n);
			ptr_out_q <= PTR_OUT_W'(ptr_n);
		end
	end

	assign result_out.valid         = res_valid_q;
	assign result_out.read_data     = rd_q;
	assign result_out.modified_mask = mmask_q;
	assign result_out.pointer       = ptr_out_q;

	`I2CRB_ASSERT(a_s1_hold, (s1_valid_q && !advance) |=> s1_valid_q,
		"input stage item lost while stalled")
	`I2CRB_ASSERT(a_no_overwrite, (item_in.valid && item_in.ready && s1_valid_q) |-> advance,
		"input stage overwritten before it moved on")
	`I2CRB_ASSERT(a_addr_load, $rose(addr_rcvd_q) |-> $past(do_write),
		"address flag set without a bus write")
	`I2CRB_ASSERT_ALWAYS(a_ptr_range, int'(ptr_q) < REGISTERS,
		"pointer beyond register count")

endmodule
